[design/i2c_master_random_access_top_defines.svh]
// Assertion macros shared by the I2C master engine RTL.
// No dependencies; included by files that carry assertions.
`ifndef I2C_MASTER_RANDOM_ACCESS_TOP_DEFINES_SVH
`define I2C_MASTER_RANDOM_ACCESS_TOP_DEFINES_SVH
// Implication checked on every clock outside reset.
`define I2CM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Plain check that also holds during reset.
`define I2CM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[design/i2cm_pkg.sv]
// Package for the I2C master engine: phases, stages, ops and the front/back word.
// No dependencies.
`default_nettype none
package i2cm_pkg;
  typedef enum logic [12:0] {
    PH_IDLE     = 13'b0000000000001,
    PH_CHECK    = 13'b0000000000010,
    PH_REC_LOW  = 13'b0000000000100,
    PH_REC_HIGH = 13'b0000000001000,
    PH_START_A  = 13'b0000000010000,
    PH_START_B  = 13'b0000000100000,
    PH_START_C  = 13'b0000001000000,
    PH_SETUP    = 13'b0000010000000,
    PH_HIGH     = 13'b0000100000000,
    PH_HOLD     = 13'b0001000000000,
    PH_STOP_A   = 13'b0010000000000,
    PH_STOP_B   = 13'b0100000000000,
    PH_STOP_C   = 13'b1000000000000
  } phase_t;

  typedef enum logic [1:0] {CMD_READ = 2'd0, CMD_WRITE = 2'd1, CMD_PROBE = 2'd2} cmd_t;
  typedef enum logic [2:0] {
    STG_ADDR_W = 3'd0, STG_OFFSET = 3'd1, STG_ADDR_R = 3'd2, STG_RX = 3'd3, STG_TX = 3'd4
  } stage_t;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_PROBE = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOACK = 2'd1;
  localparam logic [1:0] ST_STUCK = 2'd2;
  localparam logic [1:0] ST_LONG  = 2'd3;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Word passed from the front decoder to the engine
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] slave_address;
    logic [7:0] start_offset;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
    logic       scl_in;
  } item_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
  } result_t;
endpackage
`default_nettype wire

[design/i2cm_if.sv]
// Valid/ready channel interfaces for the I2C master engine.
// Depends on i2cm_pkg.
`default_nettype none
interface i2cm_in_if;
  logic              valid;
  logic              ready;
  i2cm_pkg::item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_out_if;
  logic              valid;
  logic              ready;
  i2cm_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/i2c_master_random_access_top.sv]
// A word's result goes through the queue stage, then into the engine's output register.
// Throughput: one word per clock while the output is not stalled; each tick advances one
// bus phase in the engine, which holds the only loop-carried state.
// Reset (rst_n, synchronous, low): engine idle, buffer empty, recovery off, recovery count 9.
// Buffer contents are undefined until loaded.
`default_nettype none
module i2c_master_random_access_top #(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  i2cm_in_if.sink         in_ch,
  i2cm_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_wdata
);
  import i2cm_pkg::*;
  logic       rec_en_r;
  logic [3:0] rec_clocks_r;
  logic       q_full, q_empty, pop;
  item_t      head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_en_r <= 1'b0; rec_clocks_r <= 4'd9;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) rec_en_r <= cfg_wdata[0];
      else rec_clocks_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = !q_full;

  i2cm_queue u_queue (
    .clk, .rst_n, .push(in_ch.valid && !q_full), .push_data(in_ch.data), .full(q_full),
    .pop, .head, .empty(q_empty)
  );

  i2cm_engine #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_engine (
    .clk, .rst_n, .rec_en(rec_en_r), .rec_clocks(rec_clocks_r),
    .item_valid(!q_empty), .item(head), .item_pop(pop),
    .res_valid(out_ch.valid), .res(out_ch.data), .res_ready(out_ch.ready)
  );
endmodule
`default_nettype wire

[design/i2cm_queue.sv]
// Two-entry queue between the front input stage and the engine.
// Depends on i2cm_pkg.
`default_nettype none
module i2cm_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire i2cm_pkg::item_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output i2cm_pkg::item_t      head,
  output logic                 empty
);
  import i2cm_pkg::*;
  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r[1];
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[design/i2cm_engine.sv]
// Bus sequencer of the I2C master: at most one bus phase per word, result in an output register.
// Depends on i2cm_pkg and the defines header.
`default_nettype none
`include "i2c_master_random_access_top_defines.svh"
module i2cm_engine #(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rec_en,
  input  wire logic [3:0]        rec_clocks,
  input  wire logic              item_valid,
  input  wire i2cm_pkg::item_t   item,
  output logic                   item_pop,
  output logic                   res_valid,
  output i2cm_pkg::result_t      res,
  input  wire logic              res_ready
);
  import i2cm_pkg::*;
  localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);

  phase_t      ph_r, ph_nxt;
  stage_t      stg_r, stg_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [3:0]  bc_r, bc_nxt, rc_r, rc_nxt;
  logic [7:0]  sh_r, sh_nxt, rem_r, rem_nxt, addr_r, addr_nxt, offs_r, offs_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [8:0]  wi_r, wi_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  wbuf [BUFFER_DEPTH];
  logic        res_valid_r;
  result_t     res_r, r;
  logic        slot, take;

  assign take = item_valid && (!res_valid_r || res_ready);
  assign item_pop = take;
  assign res_valid = res_valid_r;
  assign res = res_r;

  // level on SDA for the current data or acknowledge slot
  always_comb begin
    if (stg_r == STG_RX) slot = (bc_r < BITS_PER_BYTE) ? 1'b1 : (rem_r <= 8'd1);
    else slot = (bc_r < BITS_PER_BYTE) ? sh_r[7] : 1'b1;
  end

  // next state and result
  always_comb begin
    ph_nxt = ph_r; stg_nxt = stg_r; cmd_nxt = cmd_r; bc_nxt = bc_r; rc_nxt = rc_r;
    sh_nxt = sh_r; rem_nxt = rem_r; addr_nxt = addr_r; offs_nxt = offs_r;
    fill_nxt = fill_r; wi_nxt = wi_r; pend_nxt = pend_r;
    r = '0;
    r.scl_drive = 1'b1; r.sda_drive = 1'b1;
    case (ph_r)
      PH_REC_LOW: r.scl_drive = 1'b0;
      PH_START_B: r.sda_drive = 1'b0;
      PH_START_C: begin r.scl_drive = 1'b0; r.sda_drive = 1'b0; end
      PH_SETUP, PH_HOLD: begin r.scl_drive = 1'b0; r.sda_drive = slot; end
      PH_HIGH: r.sda_drive = slot;
      PH_STOP_A: begin r.scl_drive = 1'b0; r.sda_drive = 1'b0; end
      PH_STOP_B: r.sda_drive = 1'b0;
      default: ;
    endcase
    if (ph_r == PH_IDLE) begin
      case (item.op)
        OP_LOAD: if (fill_r < DEPTH_F) fill_nxt = fill_r + 1'b1;
        OP_READ, OP_WRITE, OP_PROBE: begin
          cmd_nxt = (item.op == OP_READ) ? CMD_READ :
                    (item.op == OP_WRITE) ? CMD_WRITE : CMD_PROBE;
          if (item.op == OP_WRITE && {1'b0, item.byte_count} > 9'(fill_r)) begin
            fill_nxt = '0; r.done_res = 1'b1; r.status = ST_LONG;
          end else begin
            addr_nxt = {item.slave_address[7:1], 1'b0};
            offs_nxt = item.start_offset;
            sh_nxt = {item.slave_address[7:1], 1'b0};
            bc_nxt = '0; stg_nxt = STG_ADDR_W; wi_nxt = '0; pend_nxt = 1'b0;
            if (item.op == OP_READ)
              rem_nxt = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
            else if (item.op == OP_WRITE) rem_nxt = item.byte_count;
            else rem_nxt = 8'd0;
            ph_nxt = rec_en ? PH_CHECK : PH_START_A;
          end
        end
        default: ;
      endcase
    end else if (item.op == OP_TICK) begin
      case (ph_r)
        PH_CHECK:
          if (item.scl_in && item.sda_in) ph_nxt = PH_START_A;
          else if (item.scl_in && rec_clocks != 4'd0) begin
            rc_nxt = rec_clocks; ph_nxt = PH_REC_LOW;
          end else begin
            if (item.scl_in) rc_nxt = rec_clocks;
            ph_nxt = PH_IDLE; r.done_res = 1'b1; r.status = ST_STUCK;
            if (cmd_r == CMD_WRITE) fill_nxt = '0;
          end
        PH_REC_LOW: ph_nxt = PH_REC_HIGH;
        PH_REC_HIGH:
          if (item.sda_in) ph_nxt = PH_START_A;
          else begin
            rc_nxt = rc_r - 4'd1;
            if (rc_nxt == 4'd0) begin
              ph_nxt = PH_IDLE; r.done_res = 1'b1; r.status = ST_STUCK;
              if (cmd_r == CMD_WRITE) fill_nxt = '0;
            end else ph_nxt = PH_REC_LOW;
          end
        PH_START_A: ph_nxt = PH_START_B;
        PH_START_B: ph_nxt = PH_START_C;
        PH_START_C: begin bc_nxt = '0; ph_nxt = PH_SETUP; end
        PH_SETUP: ph_nxt = PH_HIGH;
        PH_HIGH: begin
          if (stg_r == STG_RX && bc_r < BITS_PER_BYTE) begin
            sh_nxt = {sh_r[6:0], item.sda_in};
            if (bc_r == 4'd7) begin
              r.read_valid = 1'b1; r.read_byte = sh_nxt; r.read_last = (rem_r <= 8'd1);
            end
          end else if (stg_r != STG_RX && bc_r >= BITS_PER_BYTE && item.sda_in)
            pend_nxt = 1'b1;
          ph_nxt = PH_HOLD;
        end
        PH_HOLD:
          if (bc_r < BITS_PER_BYTE) begin
            if (stg_r != STG_RX) sh_nxt = {sh_r[6:0], 1'b0};
            bc_nxt = bc_r + 4'd1; ph_nxt = PH_SETUP;
          end else begin
            bc_nxt = '0;
            if (pend_r) ph_nxt = PH_STOP_A;
            else begin
              case (stg_r)
                STG_ADDR_W:
                  if (cmd_r == CMD_PROBE) ph_nxt = PH_STOP_A;
                  else begin stg_nxt = STG_OFFSET; sh_nxt = offs_r; ph_nxt = PH_SETUP; end
                STG_OFFSET:
                  if (cmd_r == CMD_READ) begin
                    stg_nxt = STG_ADDR_R; sh_nxt = addr_r | 8'h01; ph_nxt = PH_START_A;
                  end else begin
                    wi_nxt = '0;
                    if (rem_r == 8'd0) ph_nxt = PH_STOP_A;
                    else begin
                      stg_nxt = STG_TX; sh_nxt = wbuf[0]; ph_nxt = PH_SETUP;
                    end
                  end
                STG_ADDR_R: begin stg_nxt = STG_RX; sh_nxt = '0; ph_nxt = PH_SETUP; end
                STG_RX:
                  if (rem_r <= 8'd1) begin rem_nxt = '0; ph_nxt = PH_STOP_A; end
                  else begin rem_nxt = rem_r - 8'd1; ph_nxt = PH_SETUP; end
                default: begin
                  if (rem_r != 8'd0) rem_nxt = rem_r - 8'd1;
                  wi_nxt = wi_r + 9'd1;
                  if (rem_nxt == 8'd0) ph_nxt = PH_STOP_A;
                  else begin
                    stg_nxt = STG_TX;
                    sh_nxt = (wi_nxt < 9'(BUFFER_DEPTH)) ? wbuf[wi_nxt[IW-1:0]] : 8'd0;
                    ph_nxt = PH_SETUP;
                  end
                end
              endcase
            end
          end
        PH_STOP_A: ph_nxt = PH_STOP_B;
        PH_STOP_B: ph_nxt = PH_STOP_C;
        PH_STOP_C: begin
          ph_nxt = PH_IDLE; r.done_res = 1'b1; r.status = pend_r ? ST_NOACK : ST_OK;
          if (cmd_r == CMD_WRITE) fill_nxt = '0;
        end
        default: ph_nxt = PH_IDLE;
      endcase
    end
    r.busy_res = (ph_nxt != PH_IDLE);
  end

  // write buffer
  always_ff @(posedge clk) begin
    if (take && ph_r == PH_IDLE && item.op == OP_LOAD && fill_r < DEPTH_F)
      wbuf[fill_r[IW-1:0]] <= item.write_byte;
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; stg_r <= STG_ADDR_W; cmd_r <= CMD_READ; bc_r <= '0; rc_r <= '0;
      sh_r <= '0; rem_r <= '0; addr_r <= '0; offs_r <= '0; fill_r <= '0; wi_r <= '0;
      pend_r <= 1'b0; res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        ph_r <= ph_nxt; stg_r <= stg_nxt; cmd_r <= cmd_nxt; bc_r <= bc_nxt; rc_r <= rc_nxt;
        sh_r <= sh_nxt; rem_r <= rem_nxt; addr_r <= addr_nxt; offs_r <= offs_nxt;
        fill_r <= fill_nxt; wi_r <= wi_nxt; pend_r <= pend_nxt;
        res_r <= r;
        res_valid_r <= 1'b1;
      end else if (res_ready) res_valid_r <= 1'b0;
    end
  end

  `I2CM_ASSERT(a_fill_bound, clk, rst_n, fill_r <= DEPTH_F, "buffer fill beyond depth")
  `I2CM_ASSERT(a_done_idle, clk, rst_n, (res_valid_r && res_r.done_res) |-> !res_r.busy_res, "done while busy")
  `I2CM_ASSERT(a_hold_stall, clk, rst_n, (res_valid_r && !res_ready) |=> $stable(res_r), "result changed while stalled")
  `I2CM_ASSERT_ALWAYS(a_phase_onehot, clk, $onehot(ph_r) || !rst_n, "phase not one-hot")
endmodule
`default_nettype wire
